// ===== src/fcrr_pkg.sv =====
// Shared types, constants and the CRC-16/XMODEM step for the framed CRC receiver.
`timescale 1ns / 1ps
`default_nettype none

package fcrr_pkg;

   localparam int FRAME_CAPACITY_DEF = 32;

   localparam logic [4:0] MAX_DELIVER = 5'd26;

   localparam logic [7:0] SOF_BYTE  = 8'h7f;
   localparam logic [7:0] EOF_BYTE  = 8'hfe;
   localparam logic [7:0] KIND_CTRL = 8'h43;
   localparam logic [7:0] KIND_DATA = 8'h44;
   localparam logic [7:0] CTRL_LEN  = 8'h01;

   localparam logic [2:0] CODE_ACK       = 3'd1;
   localparam logic [2:0] CODE_CRC_FAIL  = 3'd2;
   localparam logic [2:0] CODE_OVERSIZE  = 3'd3;
   localparam logic [2:0] CODE_INVALID   = 3'd4;
   localparam logic [2:0] CODE_HEARTBEAT = 3'd5;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_PAY_READ,
      ST_PAY_OUT,
      ST_CTRL_OUT
   } state_type;

   typedef struct packed {
      logic take;
      logic pay_read;
      logic pay_emit;
      logic ctrl_emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic reply;
      logic deliver;
      logic pay_last;
      logic ctrl_last;
      logic out_free;
   } dp_status_type;

   function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== src/fcrr_ctrl.sv =====
// Controller state machine: sequences byte intake, payload delivery and reply frames.
`timescale 1ns / 1ps
`default_nettype none

module fcrr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  fcrr_pkg::dp_status_type status,
   output fcrr_pkg::ctl_cmd_type   cmd
);
   import fcrr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!status.reply) begin
               state_in = ST_IDLE;
            end else if (status.deliver) begin
               state_in = ST_PAY_READ;
            end else begin
               state_in = ST_CTRL_OUT;
            end
         end
         ST_PAY_READ: begin
            cmd.pay_read = 1'b1;
            state_in     = ST_PAY_OUT;
         end
         ST_PAY_OUT: begin
            if (status.out_free) begin
               cmd.pay_emit = 1'b1;
               state_in     = status.pay_last ? ST_CTRL_OUT : ST_PAY_READ;
            end
         end
         ST_CTRL_OUT: begin
            if (status.out_free) begin
               cmd.ctrl_emit = 1'b1;
               if (status.ctrl_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take, cmd.pay_read, cmd.pay_emit, cmd.ctrl_emit}))
      else $error("more than one datapath command at once");

   a_take_eval: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> state_ff == ST_EVAL)
      else $error("accepted byte not evaluated");

   a_reply_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.ctrl_emit && status.ctrl_last) |=> state_ff == ST_IDLE)
      else $error("controller did not return to idle after reply frame");
`endif

endmodule

`default_nettype wire

// ===== src/fcrr_datapath.sv =====
// Datapath: frame store, header and CRC checks, result selection and output register.
`timescale 1ns / 1ps
`default_nettype none

module fcrr_datapath #(
   parameter int FRAME_CAPACITY = fcrr_pkg::FRAME_CAPACITY_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fcrr_pkg::ctl_cmd_type   cmd,
   output fcrr_pkg::dp_status_type status,
   input  logic [7:0]              rx_byte,
   input  logic                    csr_wr_en,
   input  logic [4:0]              csr_wr_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_out_kind,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_out_last
);
   import fcrr_pkg::*;

   localparam int CW = $clog2(FRAME_CAPACITY + 1);
   localparam int AW = $clog2(FRAME_CAPACITY);
   localparam logic [CW-1:0] CapCount = CW'(FRAME_CAPACITY);
   localparam logic [7:0] MaxLen = 8'(FRAME_CAPACITY - 6);
   localparam logic [2:0] CtrlLastIdx = 3'd6;

   logic [4:0]    max_copy_ff, max_copy_in;
   logic [CW-1:0] count_ff, count_in;
   logic          phase_ff, phase_in;
   logic [CW-1:0] len_ff, len_in;
   logic [15:0]   crc_ff, crc_in;
   logic          sof_ok_ff, sof_ok_in;
   logic [7:0]    type_ff, type_in;
   logic [7:0]    pay0_ff, pay0_in;
   logic [7:0]    prev1_ff, prev1_in;
   logic [7:0]    prev2_ff, prev2_in;
   logic          reply_ff, reply_in;
   logic [2:0]    code_ff, code_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [4:0]    pay_idx_ff, pay_idx_in;
   logic [2:0]    ctrl_idx_ff, ctrl_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_kind_ff, rsp_kind_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [7:0]    rd_data_ff;

   logic [7:0]    mem [FRAME_CAPACITY];

   logic          active;
   logic          wrap;
   logic [CW-1:0] idx;
   logic [CW-1:0] idx_next;
   logic          phase_cur;
   logic [15:0]   crc_cur;
   logic [5:0]    rd_sum;
   logic [AW-1:0] rd_addr;
   logic [15:0]   reply_crc;
   logic [7:0]    ctrl_byte;
   logic          out_free;

   assign active    = cmd.take && (max_copy_ff != 5'd0);
   assign wrap      = count_ff >= CapCount;
   assign idx       = wrap ? '0 : count_ff;
   assign idx_next  = idx + CW'(1);
   assign phase_cur = wrap ? 1'b0 : phase_ff;
   assign crc_cur   = wrap ? 16'h0000 : crc_ff;
   assign rd_sum    = 6'(pay_idx_ff) + 6'd3;
   assign rd_addr   = rd_sum[AW-1:0];
   assign reply_crc = crc_add(16'h0000, {5'b00000, code_ff});
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (ctrl_idx_ff)
         3'd0:    ctrl_byte = SOF_BYTE;
         3'd1:    ctrl_byte = KIND_CTRL;
         3'd2:    ctrl_byte = CTRL_LEN;
         3'd3:    ctrl_byte = {5'b00000, code_ff};
         3'd4:    ctrl_byte = reply_crc[7:0];
         3'd5:    ctrl_byte = reply_crc[15:8];
         default: ctrl_byte = EOF_BYTE;
      endcase
   end

   // frame assembly and checks
   always_comb begin
      max_copy_in = max_copy_ff;
      count_in    = count_ff;
      phase_in    = phase_ff;
      len_in      = len_ff;
      crc_in      = crc_ff;
      sof_ok_in   = sof_ok_ff;
      type_in     = type_ff;
      pay0_in     = pay0_ff;
      prev1_in    = prev1_ff;
      prev2_in    = prev2_ff;
      reply_in    = reply_ff;
      code_in     = code_ff;
      cnt_in      = cnt_ff;
      pay_idx_in  = pay_idx_ff;
      ctrl_idx_in = ctrl_idx_ff;

      if (csr_wr_en) begin
         max_copy_in = (csr_wr_data > MAX_DELIVER) ? MAX_DELIVER : csr_wr_data;
      end

      if (cmd.take) begin
         reply_in    = 1'b0;
         cnt_in      = '0;
         pay_idx_in  = '0;
         ctrl_idx_in = '0;
      end

      if (active) begin
         count_in = idx_next;
         phase_in = phase_cur;
         crc_in   = crc_cur;
         prev1_in = rx_byte;
         prev2_in = prev1_ff;
         if (!phase_cur) begin
            if (idx == CW'(0)) begin
               sof_ok_in = (rx_byte == SOF_BYTE);
            end
            if (idx == CW'(1)) begin
               type_in = rx_byte;
            end
            if (idx == CW'(2)) begin
               if (!sof_ok_ff) begin
                  reply_in = 1'b1;
                  code_in  = CODE_INVALID;
                  count_in = '0;
                  crc_in   = 16'h0000;
               end else if (rx_byte > MaxLen) begin
                  reply_in = 1'b1;
                  code_in  = CODE_OVERSIZE;
                  count_in = '0;
                  crc_in   = 16'h0000;
               end else begin
                  phase_in = 1'b1;
                  len_in   = rx_byte[CW-1:0];
               end
            end
         end else begin
            if (idx == CW'(3)) begin
               pay0_in = rx_byte;
            end
            if (idx_next <= len_ff + CW'(3)) begin
               crc_in = crc_add(crc_cur, rx_byte);
            end
            if (idx_next == len_ff + CW'(6)) begin
               reply_in = 1'b1;
               count_in = '0;
               phase_in = 1'b0;
               crc_in   = 16'h0000;
               if (rx_byte != EOF_BYTE) begin
                  code_in = CODE_INVALID;
               end else if ({prev1_ff, prev2_ff} != crc_cur) begin
                  code_in = CODE_CRC_FAIL;
               end else if (type_ff == KIND_CTRL && len_ff != '0 &&
                            pay0_ff == {5'b00000, CODE_HEARTBEAT}) begin
                  code_in = CODE_HEARTBEAT;
               end else if (type_ff == KIND_DATA) begin
                  code_in = CODE_ACK;
                  cnt_in  = (8'(len_ff) < {3'b000, max_copy_ff}) ? 5'(len_ff) : max_copy_ff;
               end else begin
                  code_in = CODE_INVALID;
               end
            end
         end
      end

      if (cmd.pay_emit) begin
         pay_idx_in = pay_idx_ff + 5'd1;
      end
      if (cmd.ctrl_emit) begin
         ctrl_idx_in = ctrl_idx_ff + 3'd1;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.pay_emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = 1'b0;
         rsp_byte_in  = rd_data_ff;
         rsp_last_in  = 1'b0;
      end else if (cmd.ctrl_emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = 1'b1;
         rsp_byte_in  = ctrl_byte;
         rsp_last_in  = (ctrl_idx_ff == CtrlLastIdx);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_copy_ff  <= MAX_DELIVER;
         count_ff     <= '0;
         phase_ff     <= 1'b0;
         crc_ff       <= 16'h0000;
         reply_ff     <= 1'b0;
         cnt_ff       <= '0;
         pay_idx_ff   <= '0;
         ctrl_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_copy_ff  <= max_copy_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         crc_ff       <= crc_in;
         reply_ff     <= reply_in;
         cnt_ff       <= cnt_in;
         pay_idx_ff   <= pay_idx_in;
         ctrl_idx_ff  <= ctrl_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      sof_ok_ff   <= sof_ok_in;
      type_ff     <= type_in;
      pay0_ff     <= pay0_in;
      prev1_ff    <= prev1_in;
      prev2_ff    <= prev2_in;
      code_ff     <= code_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (active) begin
         mem[idx[AW-1:0]] <= rx_byte;
      end
      if (cmd.pay_read) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign status.reply     = reply_ff;
   assign status.deliver   = (cnt_ff != 5'd0);
   assign status.pay_last  = ((pay_idx_ff + 5'd1) == cnt_ff);
   assign status.ctrl_last = (ctrl_idx_ff == CtrlLastIdx);
   assign status.out_free  = out_free;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_kind = rsp_kind_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff < CapCount)
      else $error("frame byte count reached capacity");

   a_header_count: assert property (@(posedge clock) disable iff (reset)
      !phase_ff |-> count_ff < CW'(3))
      else $error("header phase with more than two bytes held");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.pay_emit || cmd.ctrl_emit) |-> out_free)
      else $error("result register overwritten while held");
`endif

endmodule

`default_nettype wire

// ===== src/framed_crc_receiver_with_replies_core.sv =====
// Top level of the framed CRC-16/XMODEM serial receiver with reply frames.
//
//   channel  ports                                   direction
//   req      req_valid req_stall req_rx_byte         serial bytes in
//   rsp      rsp_valid rsp_stall rsp_out_kind/byte/last  payload and reply bytes out
//   csr      csr_wr_en csr_wr_data                   max_copy register write
//
// One byte is taken at a time: the next is accepted only once the controller is idle again.
// A byte that ends a frame then sends the seven-byte reply frame, preceded by each
// delivered payload byte (one single-port frame store read, then the transfer).
// Extra cycles come from rsp_stall; the last result may still wait in the
// output register while the next byte is accepted.
// Synchronous active-high reset; the frame store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module framed_crc_receiver_with_replies_core #(
   parameter int FRAME_CAPACITY = fcrr_pkg::FRAME_CAPACITY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_out_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   input  logic       csr_wr_en,
   input  logic [4:0] csr_wr_data
);
   import fcrr_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   fcrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fcrr_datapath #(
      .FRAME_CAPACITY (FRAME_CAPACITY)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .rx_byte      (req_rx_byte),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_kind (rsp_out_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

`default_nettype wire

// ===== tb/tb_framed_crc_receiver_with_replies_core.sv =====
// Self-checking testbench for the framed CRC receiver: directed and random frames against a predictor.
`timescale 1ns / 1ps

module tb_framed_crc_receiver_with_replies_core;
   import fcrr_pkg::*;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_REPLY   = 1'b1;
   localparam int   PHASES         = 6;
   localparam int   PHASE_BYTES    = 8;
   localparam int   DRAIN_CYCLES   = 16;
   localparam int   WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic       kind;
      logic [7:0] value;
      logic       last;
   } reply_beat_type;

   class frame_reply_board;
      reply_beat_type expected_out[$];
      logic [4:0]     copy_limit;
      logic           in_body;
      int unsigned    fill;
      logic [7:0]     frame_bytes[FRAME_CAPACITY_DEF];
      logic [15:0]    payload_crc;
      int unsigned    errors;
      int unsigned    rx_count;
      int unsigned    out_count;

      function void power_on();
         copy_limit = MAX_DELIVER;
         errors     = 0;
         rx_count   = 0;
         out_count  = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         in_body     = 1'b0;
         fill        = 0;
         payload_crc = 16'h0000;
      endfunction

      function void set_copy_limit(logic [4:0] v);
         copy_limit = (v > MAX_DELIVER) ? MAX_DELIVER : v;
      endfunction

      function logic [15:0] xmodem_step(logic [15:0] crc, logic [7:0] b);
         logic [15:0] c;
         c = crc ^ {b, 8'h00};
         for (int i = 0; i < 8; i++) begin
            if (c[15]) c = {c[14:0], 1'b0} ^ 16'h1021;
            else c = {c[14:0], 1'b0};
         end
         return c;
      endfunction

      function void queue_beat(logic kind, logic [7:0] value);
         reply_beat_type beat;
         beat.kind  = kind;
         beat.value = value;
         beat.last  = 1'b0;
         expected_out.push_back(beat);
      endfunction

      function void queue_reply(logic [2:0] code);
         logic [15:0] crc;
         crc = xmodem_step(16'h0000, {5'd0, code});
         queue_beat(KIND_REPLY, SOF_BYTE);
         queue_beat(KIND_REPLY, KIND_CTRL);
         queue_beat(KIND_REPLY, CTRL_LEN);
         queue_beat(KIND_REPLY, {5'd0, code});
         queue_beat(KIND_REPLY, crc[7:0]);
         queue_beat(KIND_REPLY, crc[15:8]);
         queue_beat(KIND_REPLY, EOF_BYTE);
      endfunction

      function void finish_frame();
         int unsigned len;
         int unsigned cnt;
         logic [15:0] rx_crc;
         len    = frame_bytes[2];
         rx_crc = {frame_bytes[4 + len], frame_bytes[3 + len]};
         if (frame_bytes[len + 5] != EOF_BYTE) begin
            queue_reply(CODE_INVALID);
         end else if (rx_crc != payload_crc) begin
            queue_reply(CODE_CRC_FAIL);
         end else if (frame_bytes[1] == KIND_CTRL && len >= 1 &&
                      frame_bytes[3] == {5'd0, CODE_HEARTBEAT}) begin
            queue_reply(CODE_HEARTBEAT);
         end else if (frame_bytes[1] == KIND_DATA) begin
            cnt = (len > copy_limit) ? copy_limit : len;
            for (int i = 0; i < cnt; i++) queue_beat(KIND_PAYLOAD, frame_bytes[3 + i]);
            queue_reply(CODE_ACK);
         end else begin
            queue_reply(CODE_INVALID);
         end
         restart_frame();
      endfunction

      // Notes one accepted serial byte and queues the results it causes.
      function void take_rx_byte(logic [7:0] b);
         int unsigned before_cnt;
         reply_beat_type beat;
         rx_count++;
         if (copy_limit == 0) return;
         if (fill >= FRAME_CAPACITY_DEF) restart_frame();
         frame_bytes[fill] = b;
         fill++;
         before_cnt = expected_out.size();
         if (!in_body) begin
            if (fill == 3) begin
               if (frame_bytes[0] != SOF_BYTE) begin
                  queue_reply(CODE_INVALID);
                  restart_frame();
               end else if (frame_bytes[2] > FRAME_CAPACITY_DEF - 6) begin
                  queue_reply(CODE_OVERSIZE);
                  restart_frame();
               end else begin
                  in_body = 1'b1;
               end
            end
         end else begin
            if (fill <= 3 + frame_bytes[2]) payload_crc = xmodem_step(payload_crc, b);
            if (fill == frame_bytes[2] + 6) finish_frame();
         end
         if (expected_out.size() > before_cnt) begin
            beat = expected_out.pop_back();
            beat.last = 1'b1;
            expected_out.push_back(beat);
         end
      endfunction

      function void check_out(logic kind, logic [7:0] value, logic last);
         reply_beat_type want;
         out_count++;
         if (expected_out.size() == 0) begin
            $error("unexpected result: out_kind %0d out_byte %02h out_last %0d",
                   kind, value, last);
            errors++;
            return;
         end
         want = expected_out.pop_front();
         if (kind !== want.kind) begin
            $error("out_kind: expected %0d, got %0d", want.kind, kind);
            errors++;
         end
         if (value !== want.value) begin
            $error("out_byte: expected %02h, got %02h", want.value, value);
            errors++;
         end
         if (last !== want.last) begin
            $error("out_last: expected %0d, got %0d", want.last, last);
            errors++;
         end
      endfunction

      function bit at_frame_start();
         return !in_body && fill == 0;
      endfunction

      function int pending();
         return expected_out.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_out_kind;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic       csr_wr_en = 1'b0;
   logic [4:0] csr_wr_data = 5'd0;

   frame_reply_board board;
   int unsigned send_idle_pct = 0;
   int unsigned out_stall_pct = 0;
   int unsigned phase_bytes = 0;
   int unsigned frames_sent = 0;
   int unsigned quiet_cycles = 0;
   logic [7:0]  frame_payload[$];
   int          phase_copy[PHASES]  = '{26, 31, 1, 0, 13, 26};
   int          phase_idle[PHASES]  = '{0, 80, 0, 19, 19, 0};
   int          phase_stall[PHASES] = '{0, 0, 80, 19, 19, 0};

   framed_crc_receiver_with_replies_core DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_kind (rsp_out_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < out_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_out(rsp_out_kind, rsp_out_byte, rsp_out_last);
      end
   end

   // no transfer on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.take_rx_byte(b);
      phase_bytes++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_copy_limit(input logic [4:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_copy_limit(v);
   endtask

   function automatic logic [7:0] byte_other_than(input logic [7:0] avoid);
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == avoid) b = ~avoid;
      return b;
   endfunction

   task automatic send_frame(input logic [7:0] kind, input logic [15:0] crc_flip,
                             input logic [7:0] end_byte);
      logic [15:0] crc;
      crc = 16'h0000;
      foreach (frame_payload[i]) crc = board.xmodem_step(crc, frame_payload[i]);
      crc ^= crc_flip;
      push_byte(SOF_BYTE);
      push_byte(kind);
      push_byte(8'(frame_payload.size()));
      foreach (frame_payload[i]) push_byte(frame_payload[i]);
      push_byte(crc[7:0]);
      push_byte(crc[15:8]);
      push_byte(end_byte);
      frames_sent++;
   endtask

   task automatic run_directed();
      push_byte(8'h00);
      push_byte(KIND_DATA);
      push_byte(8'h00);
      push_byte(SOF_BYTE);
      push_byte(KIND_DATA);
      push_byte(8'hff);
      frame_payload = '{{5'd0, CODE_HEARTBEAT}};
      send_frame(KIND_CTRL, 16'h0000, EOF_BYTE);
      frame_payload = {};
      send_frame(KIND_CTRL, 16'h0000, EOF_BYTE);
      frame_payload = '{8'h00, 8'hff};
      send_frame(KIND_DATA, 16'h0000, EOF_BYTE);
   endtask

   task automatic send_random_frame();
      int unsigned pick;
      int unsigned len;
      int unsigned flavor;
      logic [7:0]  kind;
      logic [15:0] crc_flip;
      logic [7:0]  end_byte;
      pick = $urandom_range(99);
      if (pick < 6) begin
         push_byte(byte_other_than(SOF_BYTE));
         push_byte(8'($urandom_range(255)));
         push_byte(8'($urandom_range(255)));
         return;
      end
      if (pick < 12) begin
         push_byte(SOF_BYTE);
         push_byte(KIND_DATA);
         push_byte($urandom_range(1) ? 8'd27 : 8'($urandom_range(255, 27)));
         return;
      end
      if (pick < 16) begin
         // line noise, then bytes until the receiver is back at a frame boundary
         repeat ($urandom_range(5, 1)) push_byte(8'($urandom_range(255)));
         while (!board.at_frame_start()) push_byte(byte_other_than(SOF_BYTE));
         return;
      end
      flavor = $urandom_range(99);
      if (flavor < 70) len = $urandom_range(8);
      else if (flavor < 90) len = $urandom_range(25, 9);
      else len = FRAME_CAPACITY_DEF - 6;
      flavor = $urandom_range(9);
      if (flavor < 5) kind = KIND_DATA;
      else if (flavor < 8) kind = KIND_CTRL;
      else kind = 8'($urandom_range(255));
      frame_payload = {};
      repeat (len) frame_payload.push_back(8'($urandom_range(255)));
      if (kind == KIND_CTRL && len >= 1 && $urandom_range(1))
         frame_payload[0] = {5'd0, CODE_HEARTBEAT};
      crc_flip = 16'h0000;
      end_byte = EOF_BYTE;
      flavor   = $urandom_range(99);
      if (flavor < 10) crc_flip = 16'($urandom_range(65535, 1));
      else if (flavor < 18) end_byte = byte_other_than(EOF_BYTE);
      send_frame(kind, crc_flip, end_byte);
   endtask

   initial begin
      board = new;
      board.power_on();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         write_copy_limit(5'(phase_copy[ph]));
         send_idle_pct = phase_idle[ph];
         out_stall_pct = phase_stall[ph];
         if (ph == 0) run_directed();
         phase_bytes = 0;
         if (phase_copy[ph] == 0) begin
            // reception disabled: everything is dropped
            repeat (10) push_byte(8'($urandom_range(255)));
         end else begin
            while (phase_bytes < PHASE_BYTES) send_random_frame();
         end
      end
      settle();
      $display("Covered %0d serial byte transfers and %0d result transfers, %0d framed",
               board.rx_count, board.out_count, frames_sent);
      $display("max_copy swept 26, 31 (clamped), 1, 0 (off), 13 under mixed idle and stall");
      if (board.errors == 0 && board.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
